// File: rtl/ncc_pkg.sv
// Shared constants, word types and helpers for the nearest-centroid
// confusion counter. No dependencies.
package ncc_pkg;

    localparam int NUM_CLASSES  = 6;
    localparam int SAMPLE_BITS  = 12;
    localparam int COUNT_BITS   = 16;

    // Field widths fixed by the interface.
    localparam int OP_BITS      = 2;
    localparam int CLS_BITS     = 3;
    localparam int DIST_BITS    = 13;
    localparam int CFG_IDX_BITS = 3;
    localparam int CENT_BITS    = 3 * SAMPLE_BITS;

    // Distance datapath.
    localparam int SQR_BITS      = 2 * SAMPLE_BITS;
    localparam int SQ_BITS       = SQR_BITS + 2;
    localparam int ROOT_STEPS    = (SQ_BITS + 3) / 4;
    localparam int ROOT_REG_BITS = 2 * ROOT_STEPS;
    localparam int RAD_BITS      = 4 * ROOT_STEPS;
    localparam int REM_BITS      = ROOT_REG_BITS + 3;

    // Cell phase counter.
    localparam int PH_BITS = 4;
    localparam logic [PH_BITS-1:0] PH_IDLE  = PH_BITS'(0);
    localparam logic [PH_BITS-1:0] PH_SQ_Y  = PH_BITS'(1);
    localparam logic [PH_BITS-1:0] PH_SQ_Z  = PH_BITS'(2);
    localparam logic [PH_BITS-1:0] PH_ROOT0 = PH_BITS'(3);
    localparam logic [PH_BITS-1:0] PH_CMP   = PH_BITS'(3 + ROOT_STEPS);

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_CLASSIFY = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ     = 2'd2;

    typedef struct packed {
        logic                   vld;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic [SAMPLE_BITS-1:0] z;
    } t_smp;

    typedef struct packed {
        logic                 vld;
        logic [DIST_BITS-1:0] dmin;
        logic [CLS_BITS-1:0]  pred;
    } t_best;

    typedef struct packed {
        logic                clr;
        logic                inc;
        logic                rd;
        logic [CLS_BITS-1:0] row;
        logic [CLS_BITS-1:0] col;
    } t_cmd;

    function automatic logic [SAMPLE_BITS-1:0] abs_diff(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: rtl/ncc_in_if.sv
// Input channel of the nearest-centroid confusion counter: one request word.
// Depends on ncc_pkg.
interface ncc_in_if;
    import ncc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     operation;
    logic [CLS_BITS-1:0]    actual_class;
    logic [CLS_BITS-1:0]    read_column;
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
    logic [SAMPLE_BITS-1:0] sample_z;

    modport source (
        output valid, operation, actual_class, read_column,
               sample_x, sample_y, sample_z,
        input  ready
    );

    modport sink (
        input  valid, operation, actual_class, read_column,
               sample_x, sample_y, sample_z,
        output ready
    );
endinterface

// File: rtl/ncc_out_if.sv
// Output channel of the nearest-centroid confusion counter: one result word.
// Depends on ncc_pkg.
interface ncc_out_if;
    import ncc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CLS_BITS-1:0]   predicted_class;
    logic [DIST_BITS-1:0]  min_distance;
    logic [COUNT_BITS-1:0] cell_count;

    modport source (
        output valid, predicted_class, min_distance, cell_count,
        input  ready
    );

    modport sink (
        input  valid, predicted_class, min_distance, cell_count,
        output ready
    );
endinterface

// File: rtl/ncc_cell.sv
// One class cell: centroid register, distance unit (shared squarer and
// two-bit-per-cycle square root), running-minimum stage and one matrix column.
// Depends on ncc_pkg.
module ncc_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ncc_pkg::CLS_BITS-1:0]   i_index,
    input  logic                           i_cfg_we,
    input  logic [ncc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [ncc_pkg::CENT_BITS-1:0]  i_cfg_data,
    input  ncc_pkg::t_smp                  i_smp,
    output ncc_pkg::t_smp                  o_smp,
    input  ncc_pkg::t_best                 i_best,
    output ncc_pkg::t_best                 o_best,
    input  ncc_pkg::t_cmd                  i_cmd,
    output logic [ncc_pkg::COUNT_BITS-1:0] o_count
);
    import ncc_pkg::*;

    logic [CENT_BITS-1:0]     r_centroid;
    t_smp                     r_fwd;
    t_best                    r_best, n_best;
    logic [PH_BITS-1:0]       r_ph, n_ph;
    logic [SQ_BITS-1:0]       r_acc;
    logic [SAMPLE_BITS-1:0]   r_dy, r_dz;
    logic [RAD_BITS-1:0]      r_rad, n_rad;
    logic [REM_BITS-1:0]      r_rem, n_rem;
    logic [ROOT_REG_BITS-1:0] r_root, n_root;
    logic [COUNT_BITS-1:0]    r_cnt [NUM_CLASSES];
    logic [COUNT_BITS-1:0]    r_resp;

    logic [SAMPLE_BITS-1:0]   dx, dy, dz, sq_in;
    logic [SQR_BITS-1:0]      sq;
    logic [SQ_BITS-1:0]       sum;
    logic [DIST_BITS-1:0]     own;
    logic                     row_ok, hit;
    logic [COUNT_BITS-1:0]    cur, inc_val;

    assign dx = abs_diff(r_centroid[SAMPLE_BITS-1:0], i_smp.x);
    assign dy = abs_diff(r_centroid[2*SAMPLE_BITS-1:SAMPLE_BITS], i_smp.y);
    assign dz = abs_diff(r_centroid[3*SAMPLE_BITS-1:2*SAMPLE_BITS], i_smp.z);

    // One squarer, fed x, then y, then z.
    always_comb begin
        case (r_ph)
            PH_IDLE: sq_in = dx;
            PH_SQ_Y: sq_in = r_dy;
            default: sq_in = r_dz;
        endcase
    end

    assign sq  = sq_in * sq_in;
    assign sum = r_acc + SQ_BITS'(sq);
    assign own = r_root[DIST_BITS-1:0];

    // Two root digits per cycle, restoring method.
    always_comb begin
        logic [REM_BITS-1:0]      rem;
        logic [REM_BITS-1:0]      trial;
        logic [ROOT_REG_BITS-1:0] root;
        logic [RAD_BITS-1:0]      rad;
        rem  = r_rem;
        root = r_root;
        rad  = r_rad;
        for (int j = 0; j < 2; j++) begin
            rem   = {rem[REM_BITS-3:0], rad[RAD_BITS-1 -: 2]};
            rad   = {rad[RAD_BITS-3:0], 2'b00};
            trial = REM_BITS'({root, 2'b01});
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[ROOT_REG_BITS-2:0], 1'b1};
            end else begin
                root = {root[ROOT_REG_BITS-2:0], 1'b0};
            end
        end
        n_rem  = rem;
        n_root = root;
        n_rad  = rad;
    end

    always_comb begin
        case (r_ph)
            PH_IDLE: n_ph = i_smp.vld ? PH_SQ_Y : PH_IDLE;
            PH_CMP:  n_ph = PH_IDLE;
            default: n_ph = r_ph + PH_BITS'(1);
        endcase
    end

    // Keep the incoming minimum unless this class is as close or closer.
    always_comb begin
        n_best = '0;
        if (r_ph == PH_CMP) begin
            if (!i_best.vld || (i_best.dmin >= own)) begin
                n_best.dmin = own;
                n_best.pred = i_index;
            end else begin
                n_best.dmin = i_best.dmin;
                n_best.pred = i_best.pred;
            end
            n_best.vld = 1'b1;
        end
    end

    assign row_ok  = (i_cmd.row < CLS_BITS'(NUM_CLASSES));
    assign hit     = row_ok && (i_cmd.col == i_index);
    assign cur     = row_ok ? r_cnt[i_cmd.row] : '0;
    assign inc_val = (&cur) ? cur : cur + COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centroid <= '0;
            r_fwd      <= '0;
            r_best     <= '0;
            r_ph       <= PH_IDLE;
        end else begin
            if (i_cfg_we && (i_cfg_idx == i_index)) begin
                r_centroid <= i_cfg_data;
            end
            r_fwd  <= i_smp;
            r_best <= n_best;
            r_ph   <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ph)
            PH_IDLE: begin
                r_acc <= SQ_BITS'(sq);
                r_dy  <= dy;
                r_dz  <= dz;
            end
            PH_SQ_Y: begin
                r_acc <= sum;
            end
            PH_SQ_Z: begin
                r_rad  <= RAD_BITS'(sum);
                r_rem  <= '0;
                r_root <= '0;
            end
            PH_CMP: begin
            end
            default: begin
                r_rad  <= n_rad;
                r_rem  <= n_rem;
                r_root <= n_root;
            end
        endcase
    end

    // Matrix column owned by this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_CLASSES; r++) begin
                r_cnt[r] <= '0;
            end
            r_resp <= '0;
        end else if (i_cmd.clr) begin
            for (int r = 0; r < NUM_CLASSES; r++) begin
                r_cnt[r] <= '0;
            end
            r_resp <= '0;
        end else if (i_cmd.inc) begin
            if (hit) begin
                r_cnt[i_cmd.row] <= inc_val;
            end
            r_resp <= hit ? inc_val : '0;
        end else if (i_cmd.rd) begin
            r_resp <= hit ? cur : '0;
        end
    end

    assign o_smp   = r_fwd;
    assign o_best  = r_best;
    assign o_count = r_resp;

endmodule

// File: rtl/nearest_centroid_confusion_counter.sv
// Nearest-centroid classifier with a 6x6 confusion matrix.
// Depends on ncc_pkg, ncc_in_if, ncc_out_if and ncc_cell.
//
// Usage:
//  - i_in carries one request word: classify-and-count, clear matrix or read
//    one cell. o_res returns exactly one result word per request.
//  - Centroids must be written through i_cfg_we / i_cfg_idx / i_cfg_data
//    only while the block is idle; the block itself does not enforce this.
//    Indexes beyond the last class are ignored.
//  - For a classify word the sample walks one cell per cycle down a chain
//    of six class cells; each cell forms its sum of squares (one shared
//    squarer), then its square root, then folds its distance into the
//    running minimum handed from its left neighbor. Clear, read and the
//    unused code skip the chain and go straight to the matrix command.
//  - One request is in flight at a time; i_in.ready is high when the block
//    is idle, so a new word can enter while the last result still waits.
//    The next word is taken only after the last request has moved its
//    result into the output register.
//  - When the receiver stalls, the result holds on o_res; a finished request
//    parks its result until the output register frees up.
//  - Reset zeroes all centroids and the whole matrix at once.
module nearest_centroid_confusion_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ncc_in_if.sink                           i_in,
    ncc_out_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [ncc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [ncc_pkg::CENT_BITS-1:0]    i_cfg_data
);
    import ncc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a request
    localparam logic [1:0] ST_RUN  = 2'd1;  // sample travels the chain
    localparam logic [1:0] ST_CNT  = 2'd2;  // matrix command to the cells
    localparam logic [1:0] ST_DONE = 2'd3;  // result waits for output reg

    logic [1:0]            r_state, n_state;
    logic [OP_BITS-1:0]    r_op;
    logic [CLS_BITS-1:0]   r_row, r_col, r_pred;
    logic [DIST_BITS-1:0]  r_dist;
    t_smp                  r_launch;

    logic                  r_ovld;
    logic [CLS_BITS-1:0]   r_opred;
    logic [DIST_BITS-1:0]  r_odist;
    logic [COUNT_BITS-1:0] r_ocnt;

    logic                  accept, load_out, use_cnt;
    t_cmd                  cmd;
    logic [COUNT_BITS-1:0] resp_or;

    t_smp                  w_smp   [NUM_CLASSES];
    t_best                 w_best  [NUM_CLASSES+1];
    logic [COUNT_BITS-1:0] w_count [NUM_CLASSES];

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign load_out   = (r_state == ST_DONE) && (!r_ovld || o_res.ready);
    assign use_cnt    = (r_op == OP_CLASSIFY) || (r_op == OP_READ);

    // Matrix command: issued for one cycle; classify hits the predicted column.
    always_comb begin
        cmd = '0;
        if (r_state == ST_CNT) begin
            cmd.clr = (r_op == OP_CLEAR);
            cmd.inc = (r_op == OP_CLASSIFY);
            cmd.rd  = (r_op == OP_READ);
            cmd.row = r_row;
            cmd.col = (r_op == OP_CLASSIFY) ? r_pred : r_col;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_in.operation == OP_CLASSIFY) ? ST_RUN : ST_CNT;
                end
            end
            ST_RUN: begin
                if (w_best[NUM_CLASSES].vld) begin
                    n_state = ST_CNT;
                end
            end
            ST_CNT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_launch.vld <= accept && (i_in.operation == OP_CLASSIFY);
            if (accept) begin
                r_launch.x <= i_in.sample_x;
                r_launch.y <= i_in.sample_y;
                r_launch.z <= i_in.sample_z;
            end
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Request and result payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_in.operation;
            r_row      <= i_in.actual_class;
            r_col      <= i_in.read_column;
            r_pred     <= '0;
            r_dist     <= '0;
        end else if ((r_state == ST_RUN) && w_best[NUM_CLASSES].vld) begin
            r_pred <= w_best[NUM_CLASSES].pred;
            r_dist <= w_best[NUM_CLASSES].dmin;
        end
        if (load_out) begin
            r_opred <= r_pred;
            r_odist <= r_dist;
            r_ocnt  <= use_cnt ? resp_or : '0;
        end
    end

    // Chain head: sample from the launch register, no minimum yet.
    assign w_smp[0]  = r_launch;
    assign w_best[0] = '0;

    for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_cell
        if (k < NUM_CLASSES - 1) begin : g_mid
            ncc_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_index    (CLS_BITS'(k)),
                .i_cfg_we   (i_cfg_we),
                .i_cfg_idx  (i_cfg_idx),
                .i_cfg_data (i_cfg_data),
                .i_smp      (w_smp[k]),
                .o_smp      (w_smp[k+1]),
                .i_best     (w_best[k]),
                .o_best     (w_best[k+1]),
                .i_cmd      (cmd),
                .o_count    (w_count[k])
            );
        end else begin : g_last
            ncc_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_index    (CLS_BITS'(k)),
                .i_cfg_we   (i_cfg_we),
                .i_cfg_idx  (i_cfg_idx),
                .i_cfg_data (i_cfg_data),
                .i_smp      (w_smp[k]),
                .o_smp      (),
                .i_best     (w_best[k]),
                .o_best     (w_best[k+1]),
                .i_cmd      (cmd),
                .o_count    (w_count[k])
            );
        end
    end

    // Only the addressed cell answers nonzero.
    always_comb begin
        resp_or = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            resp_or = resp_or | w_count[k];
        end
    end

    assign o_res.valid           = r_ovld;
    assign o_res.predicted_class = r_opred;
    assign o_res.min_distance    = r_odist;
    assign o_res.cell_count      = r_ocnt;

endmodule

// File: rtl/ncc_checker.sv
// Port-level checks for the nearest-centroid confusion counter, bound to
// the top level. Depends on ncc_pkg.
module ncc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [ncc_pkg::CLS_BITS-1:0]   i_pred,
    input logic [ncc_pkg::DIST_BITS-1:0]  i_dist,
    input logic [ncc_pkg::COUNT_BITS-1:0] i_count
);
    import ncc_pkg::*;

    // No result word survives reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // One request at a time: accepting a word makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accept");

    // A new result only appears as the block returns to idle.
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("new result while still busy");

    a_pred_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pred < CLS_BITS'(NUM_CLASSES)))
        else $error("predicted class out of range");

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pred) && $stable(i_dist) && $stable(i_count))
        else $error("stalled result changed");

endmodule

bind nearest_centroid_confusion_counter ncc_checker u_ncc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_pred      (o_res.predicted_class),
    .i_dist      (o_res.min_distance),
    .i_count     (o_res.cell_count)
);

// File: verif/nearest_centroid_confusion_counter_tb.sv
// Self-checking testbench for nearest_centroid_confusion_counter: drives request words,
// predicts each result word in a ledger class and compares the words field by field.
// Depends on ncc_pkg, ncc_in_if, ncc_out_if and the block under test.

typedef struct packed {
    logic [ncc_pkg::OP_BITS-1:0]     op;
    logic [ncc_pkg::CLS_BITS-1:0]    row;
    logic [ncc_pkg::CLS_BITS-1:0]    col;
    logic [ncc_pkg::SAMPLE_BITS-1:0] x;
    logic [ncc_pkg::SAMPLE_BITS-1:0] y;
    logic [ncc_pkg::SAMPLE_BITS-1:0] z;
} t_ncc_request;

typedef struct packed {
    logic [ncc_pkg::CLS_BITS-1:0]   pred;
    logic [ncc_pkg::DIST_BITS-1:0]  dmin;
    logic [ncc_pkg::COUNT_BITS-1:0] count;
} t_ncc_result;

// Shadow copy of the centroids and the matrix, plus the result words still owed.
class confusion_ledger;
    logic [ncc_pkg::CENT_BITS-1:0]  centroid [ncc_pkg::NUM_CLASSES];
    logic [ncc_pkg::COUNT_BITS-1:0] tally [ncc_pkg::NUM_CLASSES * ncc_pkg::NUM_CLASSES];
    t_ncc_result                    owed [$];
    int                             errors;

    function new();
        foreach (centroid[i]) centroid[i] = '0;
        foreach (tally[i]) tally[i] = '0;
        errors = 0;
    endfunction

    function void set_centroid(input int idx, input logic [ncc_pkg::CENT_BITS-1:0] value);
        if (idx < ncc_pkg::NUM_CLASSES) centroid[idx] = value;
    endfunction

    function logic [31:0] sq_gap(input logic [ncc_pkg::SAMPLE_BITS-1:0] a,
                                 input logic [ncc_pkg::SAMPLE_BITS-1:0] b);
        logic [31:0] d;
        d = (a >= b) ? 32'(a - b) : 32'(b - a);
        return d * d;
    endfunction

    // Floor of the Euclidean distance: exact sum of squares, then the
    // largest root whose square still fits, found one bit at a time.
    function logic [ncc_pkg::DIST_BITS-1:0] floor_distance(
        input logic [ncc_pkg::CENT_BITS-1:0] c, input t_ncc_request w);
        localparam int SB = ncc_pkg::SAMPLE_BITS;
        logic [31:0]                   sum;
        logic [ncc_pkg::DIST_BITS-1:0] root;
        logic [ncc_pkg::DIST_BITS-1:0] trial;
        sum = sq_gap(c[SB-1:0], w.x) + sq_gap(c[2*SB-1:SB], w.y)
            + sq_gap(c[3*SB-1:2*SB], w.z);
        root = '0;
        for (int b = ncc_pkg::DIST_BITS - 1; b >= 0; b--) begin
            trial = root;
            trial[b] = 1'b1;
            if (32'(trial) * 32'(trial) <= sum) root = trial;
        end
        return root;
    endfunction

    function void note_request(input t_ncc_request w);
        t_ncc_result                   r;
        logic [ncc_pkg::DIST_BITS-1:0] d;
        int                            slot;
        r = '0;
        case (w.op)
            ncc_pkg::OP_CLASSIFY: begin
                r.dmin = floor_distance(centroid[0], w);
                // Upward scan with >=, so equal floors go to the highest class.
                for (int k = 0; k < ncc_pkg::NUM_CLASSES; k++) begin
                    d = floor_distance(centroid[k], w);
                    if (r.dmin >= d) begin
                        r.dmin = d;
                        r.pred = k[ncc_pkg::CLS_BITS-1:0];
                    end
                end
                // A true class out of range classifies but counts nothing.
                if (w.row < ncc_pkg::NUM_CLASSES) begin
                    slot = w.row * ncc_pkg::NUM_CLASSES + r.pred;
                    if (tally[slot] != '1) tally[slot] = tally[slot] + 1'b1;
                    r.count = tally[slot];
                end
            end
            ncc_pkg::OP_CLEAR: begin
                foreach (tally[i]) tally[i] = '0;
            end
            ncc_pkg::OP_READ: begin
                if (w.row < ncc_pkg::NUM_CLASSES && w.col < ncc_pkg::NUM_CLASSES)
                    r.count = tally[w.row * ncc_pkg::NUM_CLASSES + w.col];
            end
            default: ;
        endcase
        owed.push_back(r);
    endfunction

    function void check_result(input t_ncc_result got);
        t_ncc_result want;
        if (owed.size() == 0) begin
            $error("unexpected result word: predicted_class %0d min_distance %0d cell_count %0d",
                   got.pred, got.dmin, got.count);
            errors++;
            return;
        end
        want = owed.pop_front();
        if (got.pred !== want.pred) begin
            $error("predicted_class: expected %0d, got %0d", want.pred, got.pred);
            errors++;
        end
        if (got.dmin !== want.dmin) begin
            $error("min_distance: expected %0d, got %0d", want.dmin, got.dmin);
            errors++;
        end
        if (got.count !== want.count) begin
            $error("cell_count: expected %0d, got %0d", want.count, got.count);
            errors++;
        end
    endfunction
endclass

module nearest_centroid_confusion_counter_tb;
    import ncc_pkg::*;

    // The block leaves code 3 unused; it must answer with an all-zero word.
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    localparam int IDLE_PCT      = 31;
    localparam int QUIET_LIMIT   = 4000;   // well above the classify latency
    localparam int TAIL_CYCLES   = 40;
    localparam int IDX_PAST_LAST = NUM_CLASSES;
    localparam int IDX_TOP       = (1 << CFG_IDX_BITS) - 1;

    localparam logic [SAMPLE_BITS-1:0] AXIS_MAX = '1;

    // How the six centroids are laid out for one random phase.
    typedef enum {PLAN_SCATTER, PLAN_CLUSTER, PLAN_SAME, PLAN_CORNERS} t_plan;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CENT_BITS-1:0]    i_cfg_data;

    ncc_in_if  in_if ();
    ncc_out_if res_if ();

    nearest_centroid_confusion_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    confusion_ledger      ledger;
    logic [CENT_BITS-1:0] cent_plan [NUM_CLASSES];   // what the registers hold
    bit                   idling;
    int unsigned          quiet_cycles = 0;
    t_ncc_request         seen_req;
    t_ncc_result          seen_res;

    always #5 i_clk = ~i_clk;

    // Result side: stall at random while idling is on, else accept every word.
    always @(posedge i_clk) begin
        res_if.ready <= !idling || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor both channels at the edge. Inputs change by nonblocking
    // assignment, so the values read here are those the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                seen_req.op  = in_if.operation;
                seen_req.row = in_if.actual_class;
                seen_req.col = in_if.read_column;
                seen_req.x   = in_if.sample_x;
                seen_req.y   = in_if.sample_y;
                seen_req.z   = in_if.sample_z;
                ledger.note_request(seen_req);
            end
            if (res_if.valid && res_if.ready) begin
                seen_res.pred  = res_if.predicted_class;
                seen_res.dmin  = res_if.min_distance;
                seen_res.count = res_if.cell_count;
                ledger.check_result(seen_res);
            end
            // Watchdog: count edges at which neither channel moves a word.
            if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("no word moved for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [CENT_BITS-1:0] point(input logic [SAMPLE_BITS-1:0] x,
                                                   input logic [SAMPLE_BITS-1:0] y,
                                                   input logic [SAMPLE_BITS-1:0] z);
        return {z, y, x};
    endfunction

    function automatic t_ncc_request word_of(input logic [OP_BITS-1:0] op,
                                             input logic [CLS_BITS-1:0] row,
                                             input logic [CLS_BITS-1:0] col,
                                             input logic [SAMPLE_BITS-1:0] x,
                                             input logic [SAMPLE_BITS-1:0] y,
                                             input logic [SAMPLE_BITS-1:0] z);
        t_ncc_request w;
        w.op  = op;
        w.row = row;
        w.col = col;
        w.x   = x;
        w.y   = y;
        w.z   = z;
        return w;
    endfunction

    // Mostly legal classes, one in ten out of range (6 or 7).
    function automatic logic [CLS_BITS-1:0] pick_class();
        if ($urandom_range(9) == 0) return CLS_BITS'($urandom_range(7, 6));
        return CLS_BITS'($urandom_range(NUM_CLASSES - 1));
    endfunction

    // Full-range axis value with the two rails weighted up.
    function automatic logic [SAMPLE_BITS-1:0] pick_axis();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0) return '0;
        if (roll == 1) return AXIS_MAX;
        return SAMPLE_BITS'($urandom_range(AXIS_MAX));
    endfunction

    // Axis value a few steps off a centroid, clamped to the converter range.
    function automatic logic [SAMPLE_BITS-1:0] near_axis(input logic [SAMPLE_BITS-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(8)) - 4;
        if (v < 0) v = 0;
        if (v > int'(AXIS_MAX)) v = int'(AXIS_MAX);
        return SAMPLE_BITS'(v);
    endfunction

    function automatic t_ncc_request random_request();
        t_ncc_request w;
        int           roll;
        int           k;
        roll = $urandom_range(99);
        if (roll < 84)      w.op = OP_CLASSIFY;
        else if (roll < 92) w.op = OP_READ;
        else if (roll < 95) w.op = OP_CLEAR;
        else                w.op = OP_UNUSED;
        w.row = pick_class();
        w.col = pick_class();
        // Half the samples land close to a centroid, where the nearest
        // decision and the floor ties are decided by a step or two.
        if ($urandom_range(1) == 1) begin
            k   = $urandom_range(NUM_CLASSES - 1);
            w.x = near_axis(cent_plan[k][SAMPLE_BITS-1:0]);
            w.y = near_axis(cent_plan[k][2*SAMPLE_BITS-1:SAMPLE_BITS]);
            w.z = near_axis(cent_plan[k][3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
        end else begin
            w.x = pick_axis();
            w.y = pick_axis();
            w.z = pick_axis();
        end
        return w;
    endfunction

    // Offer one word and hold it until the block takes it. Valid only drops
    // when an idle gap is chosen, so back-to-back words keep it high.
    task automatic send_request(input t_ncc_request w);
        if (idling && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_if.valid        <= 1'b1;
        in_if.operation    <= w.op;
        in_if.actual_class <= w.row;
        in_if.read_column  <= w.col;
        in_if.sample_x     <= w.x;
        in_if.sample_y     <= w.y;
        in_if.sample_z     <= w.z;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Drop valid and wait until every owed result word is back.
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (ledger.owed.size() != 0);
    endtask

    task automatic write_reg(input int idx, input logic [CENT_BITS-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_BITS'(idx);
        i_cfg_data <= value;
        @(posedge i_clk);
        ledger.set_centroid(idx, value);
    endtask

    // Write all six centroids from the plan, then hit the two indexes past
    // the last class with junk; the block must drop those writes.
    task automatic load_plan();
        for (int k = 0; k < NUM_CLASSES; k++) write_reg(k, cent_plan[k]);
        write_reg(IDX_PAST_LAST, CENT_BITS'({$urandom, $urandom}));
        write_reg(IDX_TOP, '1);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic plan_centroids(input t_plan shape);
        logic [SAMPLE_BITS-1:0] bx;
        logic [SAMPLE_BITS-1:0] by;
        logic [SAMPLE_BITS-1:0] bz;
        bx = SAMPLE_BITS'($urandom_range(AXIS_MAX - 8, 8));
        by = SAMPLE_BITS'($urandom_range(AXIS_MAX - 8, 8));
        bz = SAMPLE_BITS'($urandom_range(AXIS_MAX - 8, 8));
        for (int k = 0; k < NUM_CLASSES; k++) begin
            case (shape)
                PLAN_SCATTER: cent_plan[k] = point(pick_axis(), pick_axis(), pick_axis());
                // Tight cluster: distances differ by fractions, floors tie often.
                PLAN_CLUSTER: cent_plan[k] = point(SAMPLE_BITS'(bx + $urandom_range(3)),
                                                   SAMPLE_BITS'(by + $urandom_range(3)),
                                                   SAMPLE_BITS'(bz + $urandom_range(3)));
                // Every class equal: class 5 must win every time.
                PLAN_SAME:    cent_plan[k] = point(bx, by, bz);
                default:      cent_plan[k] = point($urandom_range(1) ? AXIS_MAX : '0,
                                                   $urandom_range(1) ? AXIS_MAX : '0,
                                                   $urandom_range(1) ? AXIS_MAX : '0);
            endcase
        end
    endtask

    task automatic random_phase(input t_plan shape, input int items, input bit idle);
        plan_centroids(shape);
        load_plan();
        idling = idle;
        repeat (items) send_request(random_request());
        drain();
    endtask

    initial begin
        ledger = new();
        idling = 1'b1;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        in_if.valid        <= 1'b0;
        in_if.operation    <= OP_CLASSIFY;
        in_if.actual_class <= '0;
        in_if.read_column  <= '0;
        in_if.sample_x     <= '0;
        in_if.sample_y     <= '0;
        in_if.sample_z     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed layout: one centroid on each rail, a close pair for ties.
        cent_plan[0] = point(0, 0, 0);
        cent_plan[1] = point(1000, 1000, 1000);
        cent_plan[2] = point(1002, 1000, 1000);
        cent_plan[3] = point(2000, 3000, 1000);
        cent_plan[4] = point(4000, 100, 2500);
        cent_plan[5] = point(AXIS_MAX, AXIS_MAX, AXIS_MAX);
        load_plan();

        send_request(word_of(OP_READ, 0, 0, 0, 0, 0));             // fresh matrix reads zero
        send_request(word_of(OP_CLASSIFY, 0, 0, 0, 0, 0));
        send_request(word_of(OP_CLASSIFY, 5, 0, AXIS_MAX, AXIS_MAX, AXIS_MAX));
        send_request(word_of(OP_CLASSIFY, 1, 0, 1001, 1000, 1000)); // exact tie, class 2 wins
        send_request(word_of(OP_CLASSIFY, 2, 0, 1001, 1001, 1000)); // floors tie at 1
        send_request(word_of(OP_CLASSIFY, 1, 0, 1000, 1000, 1000));
        send_request(word_of(OP_CLASSIFY, 7, 7, 2000, 3000, 1000)); // row out of range
        send_request(word_of(OP_CLASSIFY, 6, 0, 4000, 100, 2500));
        send_request(word_of(OP_CLASSIFY, 4, 0, AXIS_MAX, 0, AXIS_MAX));
        send_request(word_of(OP_READ, 1, 2, 0, 0, 0));
        send_request(word_of(OP_READ, 2, 2, 0, 0, 0));
        send_request(word_of(OP_READ, 6, 0, 0, 0, 0));             // cells out of range
        send_request(word_of(OP_READ, 0, 7, 0, 0, 0));
        send_request(word_of(OP_READ, 7, 7, AXIS_MAX, AXIS_MAX, AXIS_MAX));
        send_request(word_of(OP_UNUSED, 7, 7, AXIS_MAX, AXIS_MAX, AXIS_MAX));
        send_request(word_of(OP_CLEAR, 5, 5, AXIS_MAX, 0, AXIS_MAX));
        send_request(word_of(OP_READ, 0, 0, 0, 0, 0));
        send_request(word_of(OP_READ, 2, 2, 0, 0, 0));
        drain();

        // All centroids in the far corner: largest distance, six-way tie.
        foreach (cent_plan[k]) cent_plan[k] = point(AXIS_MAX, AXIS_MAX, AXIS_MAX);
        load_plan();
        send_request(word_of(OP_CLASSIFY, 3, 0, 0, 0, 0));
        send_request(word_of(OP_CLASSIFY, 0, 0, AXIS_MAX, AXIS_MAX, AXIS_MAX));
        drain();

        // Random phases; the cluster phase runs with no idling on either side.
        random_phase(PLAN_SCATTER, 150, 1'b1);
        random_phase(PLAN_CLUSTER, 150, 1'b0);
        random_phase(PLAN_SAME, 90, 1'b1);
        random_phase(PLAN_CORNERS, 140, 1'b1);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (ledger.owed.size() != 0)
            $error("%0d result words never arrived", ledger.owed.size());
        if (ledger.errors == 0 && ledger.owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
